FILE: src/gle_pkg.sv
// Shared constants, types and helper functions of the LZW code emitter.
package gle_pkg;

    localparam int MAX_CODES    = 4096;
    localparam int MAX_SYMBOLS  = 256;
    localparam int CODE_W       = $clog2(MAX_CODES);
    localparam int SYM_W        = $clog2(MAX_SYMBOLS);
    localparam int DICT_AW      = CODE_W + SYM_W;
    localparam int DICT_DEPTH   = MAX_CODES * MAX_SYMBOLS;
    localparam int CLEAR_LIMIT  = MAX_CODES - 2;
    localparam int WIDTH_W      = 4;
    localparam int CSIZE_W      = 4;
    localparam int STRIDE_W     = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int MIN_CSIZE    = 1;
    localparam int MAX_CSIZE    = 8;
    localparam int EPOCH_W      = 8;
    localparam int EPOCH_MAX    = (1 << EPOCH_W) - 1;
    localparam int MAX_RESULTS  = 4;
    localparam int PEND_IDX_W   = $clog2(MAX_RESULTS);
    localparam int PEND_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_CODE_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [CSIZE_W-1:0]  code_size;
        logic [STRIDE_W-1:0] symbol_count;
    } cfg_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             new_frame;
        logic             frame_end;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  value;
        logic [WIDTH_W-1:0] width;
        logic               last;
    } code_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CODE_W-1:0]  code;
    } entry_t;

    function automatic logic [WIDTH_W-1:0] bit_length(input logic [CODE_W-1:0] v);
        logic [WIDTH_W-1:0] n;
        n = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (v[i])
            begin
                n = WIDTH_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: src/gle_front.sv
// Front end: input transaction acceptance, frame classification and item queue.
module gle_front
    import gle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [SYM_W-1:0] symbol,
    input  logic             frame_start,
    input  logic             frame_end,
    output logic             q_valid,
    output item_t            q_item,
    input  logic             q_pop
);

    item_t               q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                open_reg;
    logic                accept;
    logic                do_pop;
    item_t               push_item;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign do_pop   = q_pop && q_valid;

    always_comb
    begin
        push_item.symbol    = symbol;
        push_item.new_frame = frame_start || !open_reg;
        push_item.frame_end = frame_end;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!accept && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            open_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
                open_reg   <= !frame_end;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

FILE: src/gle_back.sv
// Back end: dictionary lookup and update, code generation and output register.
module gle_back
    import gle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CODE_W-1:0]  code_value,
    output logic [WIDTH_W-1:0] code_width,
    output logic               last_code
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_LOOK,
        ST_DECIDE
    } state_t;

    entry_t               dict_mem [DICT_DEPTH];

    state_t               state_reg;
    item_t                item_reg;
    logic [DICT_AW-1:0]   addr_reg;
    entry_t               rd_data_reg;
    logic [CODE_W-1:0]    next_code_reg;
    logic [CODE_W-1:0]    prefix_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [DICT_AW-1:0]   sweep_cnt_reg;
    code_t                pend_reg [MAX_RESULTS];
    logic [PEND_CNT_W-1:0] pend_cnt_reg;
    logic [PEND_CNT_W-1:0] pend_idx_reg;
    code_t                out_reg;
    logic                 out_valid_reg;

    logic [DICT_AW-1:0]   prod;
    logic [DICT_AW-1:0]   look_addr;
    logic                 look_go;
    logic                 pend_empty;
    logic                 decide_go;
    logic                 drain_go;
    logic [CSIZE_W-1:0]   cs_eff;
    logic [CODE_W-1:0]    clear_code;

    code_t                lst [MAX_RESULTS];
    logic [PEND_CNT_W-1:0] lst_cnt;
    logic [CODE_W-1:0]    nc_next;
    logic [CODE_W-1:0]    pf_next;
    logic                 bump;
    logic                 dict_wr;
    logic [EPOCH_W-1:0]   epoch_bumped;
    logic                 wrap;

    logic                 mem_we;
    logic [DICT_AW-1:0]   mem_waddr;
    entry_t               mem_wdata;

    assign prod       = DICT_AW'(prefix_reg) * DICT_AW'(cfg.symbol_count);
    assign look_addr  = prod + DICT_AW'(q_item.symbol);
    assign look_go    = (state_reg == ST_LOOK) && q_valid;
    assign q_pop      = look_go;
    assign pend_empty = (pend_idx_reg == pend_cnt_reg);
    assign decide_go  = (state_reg == ST_DECIDE) && pend_empty;
    assign drain_go   = !pend_empty && (!out_valid_reg || !out_stall);

    assign out_valid  = out_valid_reg;
    assign code_value = out_reg.value;
    assign code_width = out_reg.width;
    assign last_code  = out_reg.last;

    always_comb
    begin
        if (cfg.code_size < CSIZE_W'(MIN_CSIZE))
        begin
            cs_eff = CSIZE_W'(MIN_CSIZE);
        end
        else if (cfg.code_size > CSIZE_W'(MAX_CSIZE))
        begin
            cs_eff = CSIZE_W'(MAX_CSIZE);
        end
        else
        begin
            cs_eff = cfg.code_size;
        end
        clear_code = CODE_W'(1) << cs_eff;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            lst[i] = '0;
        end
        lst_cnt = '0;
        nc_next = next_code_reg;
        pf_next = prefix_reg;
        bump    = 1'b0;
        dict_wr = 1'b0;

        if (item_reg.new_frame)
        begin
            lst[0].value = clear_code;
            lst[0].width = bit_length(clear_code + CODE_W'(1));
            lst_cnt      = PEND_CNT_W'(1);
            nc_next      = clear_code + CODE_W'(2);
            pf_next      = CODE_W'(item_reg.symbol);
            bump         = 1'b1;
        end
        else if (rd_data_reg.epoch == epoch_reg)
        begin
            pf_next = rd_data_reg.code;
        end
        else
        begin
            lst[0].value = prefix_reg;
            lst[0].width = bit_length(next_code_reg - CODE_W'(1));
            lst_cnt      = PEND_CNT_W'(1);
            if (next_code_reg > CODE_W'(CLEAR_LIMIT))
            begin
                lst[1].value = clear_code;
                lst[1].width = lst[0].width;
                lst_cnt      = PEND_CNT_W'(2);
                nc_next      = clear_code + CODE_W'(2);
                bump         = 1'b1;
            end
            else
            begin
                dict_wr = 1'b1;
                nc_next = next_code_reg + CODE_W'(1);
            end
            pf_next = CODE_W'(item_reg.symbol);
        end

        if (item_reg.frame_end)
        begin
            lst[lst_cnt[PEND_IDX_W-1:0]].value = pf_next;
            lst[lst_cnt[PEND_IDX_W-1:0]].width = bit_length(nc_next - CODE_W'(1));
            lst[lst_cnt[PEND_IDX_W-1:0]].last  = 1'b0;
            lst[PEND_IDX_W'(lst_cnt + PEND_CNT_W'(1))].value = clear_code + CODE_W'(1);
            lst[PEND_IDX_W'(lst_cnt + PEND_CNT_W'(1))].width = bit_length(nc_next);
            lst[PEND_IDX_W'(lst_cnt + PEND_CNT_W'(1))].last  = 1'b1;
            lst_cnt = lst_cnt + PEND_CNT_W'(2);
            nc_next = '0;
            pf_next = '0;
        end
    end

    assign wrap         = bump && (epoch_reg == EPOCH_W'(EPOCH_MAX));
    assign epoch_bumped = wrap ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
        end
        else if (decide_go && dict_wr)
        begin
            mem_we          = 1'b1;
            mem_wdata.epoch = epoch_reg;
            mem_wdata.code  = next_code_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_go)
        begin
            rd_data_reg <= dict_mem[look_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            item_reg      <= '0;
            addr_reg      <= '0;
            next_code_reg <= '0;
            prefix_reg    <= '0;
            epoch_reg     <= EPOCH_W'(1);
            sweep_cnt_reg <= '0;
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                pend_reg[i] <= '0;
            end
            pend_cnt_reg  <= '0;
            pend_idx_reg  <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + DICT_AW'(1);
                    if (sweep_cnt_reg == DICT_AW'(DICT_DEPTH - 1))
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (look_go)
                    begin
                        item_reg  <= q_item;
                        addr_reg  <= look_addr;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (decide_go)
                    begin
                        for (int i = 0; i < MAX_RESULTS; i++)
                        begin
                            pend_reg[i] <= lst[i];
                        end
                        pend_cnt_reg  <= lst_cnt;
                        pend_idx_reg  <= '0;
                        next_code_reg <= nc_next;
                        prefix_reg    <= pf_next;
                        if (bump)
                        begin
                            epoch_reg <= epoch_bumped;
                        end
                        state_reg <= wrap ? ST_SWEEP : ST_LOOK;
                    end
                end
                default:
                begin
                    state_reg <= ST_SWEEP;
                end
            endcase

            if (drain_go)
            begin
                out_reg       <= pend_reg[pend_idx_reg[PEND_IDX_W-1:0]];
                out_valid_reg <= 1'b1;
                pend_idx_reg  <= pend_idx_reg + PEND_CNT_W'(1);
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: src/gif_lzw_code_emitter.sv
// Top level of the LZW code emitter: configuration registers, front end and back end.
//
// Input channel: one pixel per transaction (symbol, frame_start, frame_end) on
// in_valid / in_stall. Output channel: one LZW code per transaction
// (code_value, code_width, last_code) on out_valid / out_stall.
// Configuration: cfg_we with cfg_index 0 writes code_size, index 1 writes
// symbol_count; write only while the block is idle.
// Pixel flow: each pixel takes a dictionary read followed by a decide-and-write
// step on the dictionary memory; the next pixel is not read before that step.
// A pixel yields up to four codes; its decide step waits until earlier codes have drained.
// A pixel's first code passes the read data, pending list and output registers.
// A two-entry queue sits between the front end and the dictionary unit.
// Reset: all 1048576 dictionary entries are swept clear; the queue takes two
// transactions meanwhile and then in_stall holds. The same sweep runs after
// every 255th dictionary clear.
// When the receiver stalls, the held code stays on the output register, the
// pending codes wait, and the input queue fills before in_stall rises.
module gif_lzw_code_emitter
    import gle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SYM_W-1:0]      symbol,
    input  logic                  frame_start,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CODE_W-1:0]     code_value,
    output logic [WIDTH_W-1:0]    code_width,
    output logic                  last_code
);

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_size    <= CSIZE_W'(MAX_CSIZE);
            cfg_reg.symbol_count <= STRIDE_W'(MAX_SYMBOLS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE_SIZE:    cfg_reg.code_size    <= cfg_data[CSIZE_W-1:0];
                REG_SYMBOL_COUNT: cfg_reg.symbol_count <= cfg_data[STRIDE_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    gle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .symbol      (symbol),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    gle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_value (code_value),
        .code_width (code_width),
        .last_code  (last_code)
    );

endmodule

FILE: tb/gle_code_checker.sv
// Checker for the LZW code emitter: predicts the code stream and compares it on the output channel.
`timescale 1ns / 1ps

module gle_code_checker
    import gle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [SYM_W-1:0]      symbol,
    input  logic                  frame_start,
    input  logic                  frame_end,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CODE_W-1:0]     code_value,
    input  logic [WIDTH_W-1:0]    code_width,
    input  logic                  last_code,
    output int                    errors,
    output int                    pending,
    output int                    codes_checked,
    output int                    full_clears
);

    localparam int PRINT_CAP = 40;

    logic [CODE_W-1:0]   phrase_table [int];
    code_t               predicted_codes [$];
    int                  next_code;
    int                  prefix_code;
    logic [CSIZE_W-1:0]  code_size_q;
    logic [STRIDE_W-1:0] stride_q;

    function automatic int bits_needed(input int v);
        int n;
        n = 0;
        while (v > 0)
        begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic push_code(input int value, input int width, input logic last);
        code_t c;
        c.value = CODE_W'(value);
        c.width = WIDTH_W'(width);
        c.last  = last;
        predicted_codes.push_back(c);
    endtask

    task automatic lzw_encode_pixel(input logic [SYM_W-1:0] sym, input logic fs, input logic fe);
        int    cs;
        int    clear_code;
        int    addr;
        int    w;
        cs = int'(code_size_q);
        if (cs < MIN_CSIZE)
            cs = MIN_CSIZE;
        if (cs > MAX_CSIZE)
            cs = MAX_CSIZE;
        clear_code = 1 << cs;

        if (fs || next_code == 0)
        begin
            phrase_table.delete();
            next_code = clear_code + 2;
            push_code(clear_code, bits_needed(next_code - 1), 1'b0);
            prefix_code = int'(sym);
        end
        else
        begin
            addr = int'((longint'(prefix_code) * longint'(stride_q) + longint'(sym))
                        % longint'(DICT_DEPTH));
            if (phrase_table.exists(addr))
            begin
                prefix_code = int'(phrase_table[addr]);
            end
            else
            begin
                w = bits_needed(next_code - 1);
                push_code(prefix_code, w, 1'b0);
                if (next_code > CLEAR_LIMIT)
                begin
                    push_code(clear_code, w, 1'b0);
                    phrase_table.delete();
                    next_code = clear_code + 2;
                    full_clears++;
                end
                else
                begin
                    phrase_table[addr] = CODE_W'(next_code);
                    next_code = (next_code + 1) & (MAX_CODES - 1);
                end
                prefix_code = int'(sym);
            end
        end

        if (fe)
        begin
            push_code(prefix_code, bits_needed(next_code - 1), 1'b0);
            push_code(clear_code + 1, bits_needed(next_code), 1'b1);
            next_code = 0;
            prefix_code = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        code_t want;
        if (!rst_n)
        begin
            phrase_table.delete();
            predicted_codes.delete();
            next_code = 0;
            prefix_code = 0;
            code_size_q = CSIZE_W'(8);
            stride_q = STRIDE_W'(256);
            errors = 0;
            codes_checked = 0;
            full_clears = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CODE_SIZE)
                    code_size_q = cfg_data[CSIZE_W-1:0];
                else if (cfg_index == REG_SYMBOL_COUNT)
                    stride_q = cfg_data[STRIDE_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                codes_checked++;
                if (predicted_codes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected code %0d width %0d last %0b",
                                              code_value, code_width, last_code));
                end
                else
                begin
                    want = predicted_codes.pop_front();
                    if (code_value !== want.value)
                        report_mismatch($sformatf("code_value %0d, want %0d",
                                                  code_value, want.value));
                    if (code_width !== want.width)
                        report_mismatch($sformatf("code_width %0d, want %0d (code %0d)",
                                                  code_width, want.width, want.value));
                    if (last_code !== want.last)
                        report_mismatch($sformatf("last_code %0b, want %0b (code %0d)",
                                                  last_code, want.last, want.value));
                end
            end

            if (in_valid && !in_stall)
                lzw_encode_pixel(symbol, frame_start, frame_end);

            pending <= predicted_codes.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the LZW code emitter: clock, reset, pixel and configuration stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
    import gle_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_SEGS     = 9;
    localparam int SEG_PIXELS   = 50;
    localparam int LONG_FRAME   = 40;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_CODE_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [SYM_W-1:0]      symbol      = '0;
    logic                  frame_start = 1'b0;
    logic                  frame_end   = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [CODE_W-1:0]     code_value;
    logic [WIDTH_W-1:0]    code_width;
    logic                  last_code;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int pixels_sent = 0;
    int frames_sent = 0;
    int cycle_count = 0;
    int errors;
    int pending;
    int codes_checked;
    int full_clears;

    int seg_code_size [NUM_SEGS] = '{8, 1, 0, 15, 4, 2, 9, 3, 8};
    int seg_stride    [NUM_SEGS] = '{256, 2, 0, 511, 16, 3, 300, 5, 256};

    gif_lzw_code_emitter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .symbol      (symbol),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_value  (code_value),
        .code_width  (code_width),
        .last_code   (last_code)
    );

    gle_code_checker u_code_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .symbol        (symbol),
        .frame_start   (frame_start),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_value    (code_value),
        .code_width    (code_width),
        .last_code     (last_code),
        .errors        (errors),
        .pending       (pending),
        .codes_checked (codes_checked),
        .full_clears   (full_clears)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d codes still awaited", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_pixel(input logic [SYM_W-1:0] sym, input logic fs, input logic fe);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        symbol      <= sym;
        frame_start <= fs;
        frame_end   <= fe;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
        if (fe)
            frames_sent++;
    endtask

    task automatic drain_codes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int cs, input int stride);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CODE_SIZE;
        cfg_data  <= CFG_DATA_W'(cs);
        @(posedge clk);
        cfg_index <= REG_SYMBOL_COUNT;
        cfg_data  <= CFG_DATA_W'(stride);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_frames(input int count, input int stride);
        int               span;
        int               alpha;
        int               lo;
        int               left;
        int               len;
        logic [SYM_W-1:0] sym;
        logic             fs;
        logic             fe;
        span = (stride == 0 || stride > MAX_SYMBOLS) ? MAX_SYMBOLS : stride;
        left = count;
        while (left > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
            if (len > left)
                len = left;
            alpha = $urandom_range(1, 6);
            if (alpha > span)
                alpha = span;
            lo = $urandom_range(span - alpha);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 10)
                    sym = SYM_W'($urandom_range(255));
                else
                    sym = SYM_W'(lo + $urandom_range(alpha - 1));
                fs = (k == 0);
                fe = (k == len - 1);
                if ($urandom_range(99) < 5)
                    fs = 1'($urandom_range(1));
                if ($urandom_range(99) < 5)
                    fe = 1'($urandom_range(1));
                send_pixel(sym, fs, fe);
            end
            left -= len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no open frame, then build and hit a two-symbol phrase
        send_pixel(8'd0,   1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0,   1'b0, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0,   1'b0, 1'b0);
        // restart while open: drop the frame
        send_pixel(8'd7,   1'b1, 1'b0);
        send_pixel(8'd7,   1'b0, 1'b0);
        send_pixel(8'd7,   1'b0, 1'b0);
        send_pixel(8'd7,   1'b0, 1'b0);
        send_pixel(8'd7,   1'b0, 1'b1);
        // start and end on one pixel
        send_pixel(8'd42,  1'b1, 1'b1);
        // pixel after an end without a start
        send_pixel(8'd3,   1'b0, 1'b0);
        send_pixel(8'd200, 1'b0, 1'b0);
        send_pixel(8'd128, 1'b0, 1'b1);
        drain_codes();

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            set_config(seg_code_size[seg], seg_stride[seg]);
            case (seg % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            send_frames(SEG_PIXELS, seg_stride[seg]);
            drain_codes();
        end

        // one long frame of random pixels
        idle_pct = 0;
        stall_pct = 0;
        set_config(8, 256);
        for (int k = 0; k < LONG_FRAME; k++)
            send_pixel(SYM_W'($urandom_range(255)), k == 0, k == LONG_FRAME - 1);
        drain_codes();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d pixels in %0d closed frames, checked %0d codes, %0d full-dictionary clears",
                 pixels_sent, frames_sent, codes_checked, full_clears);
        $display("code sizes 0 to 15 and strides 0 to 511 under four handshake patterns");
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/gle_pkg.sv
src/gle_front.sv
src/gle_back.sv
src/gif_lzw_code_emitter.sv
tb/gle_code_checker.sv
tb/tb_top.sv
